// ===== sv/scmp_pkg.sv =====
// Shared constants and types for the surjection count unit.
`timescale 1ns / 1ps
package scmp_pkg;

   localparam logic [29:0] PRIME = 30'd1000000007;
   // floor(2^60 / PRIME), Barrett reciprocal
   localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);
   localparam logic [31:0] FERMAT_EXP = 32'd1000000005;
   localparam logic [4:0]  FERMAT_TOP_BIT = 5'd29;

   typedef enum logic [4:0] {
      ST_FACT_INIT,
      ST_FACT_MUL,
      ST_FACT_WAIT,
      ST_PW_SQ,
      ST_PW_SQW,
      ST_PW_ML,
      ST_PW_MLW,
      ST_INV_INIT,
      ST_INV_MUL,
      ST_INV_WAIT,
      ST_IDLE,
      ST_RDF,
      ST_TSTART,
      ST_TRD,
      ST_T1,
      ST_T1W,
      ST_T2,
      ST_T2W,
      ST_T3,
      ST_T3W
   } state_type;

   typedef enum logic {
      RET_INIT,
      RET_TERM
   } ret_type;

endpackage

// ===== sv/surjection_count_mod_prime_unit.sv =====
// Top level: sequencer driving one shared modular multiplier over the tables.
//
//   channel  ports                                           handshake
//   request  req_sequence_length, req_kind_count             start / busy
//   response rsp_count                                       rsp_valid strobe
//
// After reset the unit fills its tables (busy high): the factorial table, then
// the Fermat inverse of the top factorial, then the inverse-factorial table.
// An item with m in 1..MAX_KINDS keeps busy high while it sums m terms, each
// an exponentiation over the LENGTH_BITS bits of n and three more multiplies,
// all as round trips through the one multiplier; other m give 0 in the cycle after start.
// rsp_valid pulses for one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
module surjection_count_mod_prime_unit #(
   parameter int MAX_KINDS   = 1024,
   parameter int LENGTH_BITS = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [19:0] req_sequence_length,
   input  logic [10:0] req_kind_count,
   output logic        rsp_valid,
   output logic [29:0] rsp_count
);

   localparam int KW = $clog2(MAX_KINDS + 1);
   localparam int MW = (KW > 11) ? KW : 11;
   localparam logic [31:0] LEN_MASK = (LENGTH_BITS >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << LENGTH_BITS) - 64'd1);
   localparam logic [4:0]  LEN_TOP  = 5'(LENGTH_BITS - 1);
   localparam logic [KW-1:0] KMAX   = KW'(MAX_KINDS);

   scmp_pkg::state_type state_ff, state_in;
   scmp_pkg::ret_type   ret_ff, ret_in;
   logic [KW-1:0] k_ff, k_in, m_ff, m_in, i_ff, i_in;
   logic [29:0]   acc_ff, acc_in, base_ff, base_in, pacc_ff, pacc_in;
   logic [29:0]   fm_ff, fm_in, ifa_ff, ifa_in, ifb_ff, ifb_in, sum_ff, sum_in;
   logic [31:0]   exp_ff, exp_in;
   logic [4:0]    bit_ff, bit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [29:0]   rsp_count_ff, rsp_count_in;

   logic          mm_start, mm_done;
   logic [29:0]   mm_a, mm_b, mm_res;
   logic          f_we, i_we;
   logic [KW-1:0] f_waddr, f_raddr, i_waddr, i_raddr_a, i_raddr_b;
   logic [29:0]   f_wdata, i_wdata, f_rdata, i_rdata_a, i_rdata_b;

   logic [MW-1:0] m_wide;
   logic [KW-1:0] m_minus_i;
   scmp_pkg::state_type pw_next;
   logic [4:0]    bit_next;
   logic [30:0]   add_sum;
   logic [30:0]   sub_sum;
   logic [29:0]   new_sum;

   scmp_modmul u_modmul (
      .clock  (clock),
      .reset  (reset),
      .start  (mm_start),
      .op_a   (mm_a),
      .op_b   (mm_b),
      .done   (mm_done),
      .result (mm_res)
   );

   scmp_tables #(
      .DEPTH (MAX_KINDS + 1),
      .AW    (KW)
   ) u_tables (
      .clock     (clock),
      .f_we      (f_we),
      .f_waddr   (f_waddr),
      .f_wdata   (f_wdata),
      .f_raddr   (f_raddr),
      .f_rdata   (f_rdata),
      .i_we      (i_we),
      .i_waddr   (i_waddr),
      .i_wdata   (i_wdata),
      .i_raddr_a (i_raddr_a),
      .i_raddr_b (i_raddr_b),
      .i_rdata_a (i_rdata_a),
      .i_rdata_b (i_rdata_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scmp_pkg::ST_FACT_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff       <= ret_in;
      k_ff         <= k_in;
      m_ff         <= m_in;
      i_ff         <= i_in;
      acc_ff       <= acc_in;
      base_ff      <= base_in;
      pacc_ff      <= pacc_in;
      fm_ff        <= fm_in;
      ifa_ff       <= ifa_in;
      ifb_ff       <= ifb_in;
      sum_ff       <= sum_in;
      exp_ff       <= exp_in;
      bit_ff       <= bit_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_comb begin
      m_wide    = MW'(req_kind_count);
      m_minus_i = m_ff - i_ff;
      bit_next  = bit_ff - 5'd1;
      // after a power step: finish or move to the next exponent bit
      if (bit_ff == 5'd0) begin
         pw_next = (ret_ff == scmp_pkg::RET_INIT) ? scmp_pkg::ST_INV_INIT : scmp_pkg::ST_T1;
      end else begin
         pw_next = scmp_pkg::ST_PW_SQ;
      end
      add_sum = {1'b0, sum_ff} + {1'b0, mm_res};
      sub_sum = {1'b0, sum_ff} - {1'b0, mm_res};
      if (i_ff[0] == 1'b0) begin
         new_sum = (add_sum >= 31'(scmp_pkg::PRIME)) ?
                   30'(add_sum - 31'(scmp_pkg::PRIME)) : add_sum[29:0];
      end else begin
         new_sum = (sum_ff < mm_res) ?
                   30'(sub_sum + 31'(scmp_pkg::PRIME)) : sub_sum[29:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      k_in         = k_ff;
      m_in         = m_ff;
      i_in         = i_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      pacc_in      = pacc_ff;
      fm_in        = fm_ff;
      ifa_in       = ifa_ff;
      ifb_in       = ifb_ff;
      sum_in       = sum_ff;
      exp_in       = exp_ff;
      bit_in       = bit_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;
      mm_start     = 1'b0;
      mm_a         = pacc_ff;
      mm_b         = pacc_ff;
      f_we         = 1'b0;
      f_waddr      = k_ff;
      f_wdata      = acc_ff;
      f_raddr      = '0;
      i_we         = 1'b0;
      i_waddr      = k_ff;
      i_wdata      = acc_ff;
      i_raddr_a    = i_ff;
      i_raddr_b    = m_minus_i;

      case (state_ff)
         scmp_pkg::ST_FACT_INIT: begin
            f_we     = 1'b1;
            f_waddr  = '0;
            f_wdata  = 30'd1;
            acc_in   = 30'd1;
            k_in     = KW'(1);
            state_in = scmp_pkg::ST_FACT_MUL;
         end
         scmp_pkg::ST_FACT_MUL: begin
            mm_start = 1'b1;
            mm_a     = acc_ff;
            mm_b     = 30'(k_ff);
            state_in = scmp_pkg::ST_FACT_WAIT;
         end
         scmp_pkg::ST_FACT_WAIT: begin
            if (mm_done) begin
               f_we    = 1'b1;
               f_wdata = mm_res;
               acc_in  = mm_res;
               if (k_ff == KMAX) begin
                  base_in  = mm_res;
                  exp_in   = scmp_pkg::FERMAT_EXP;
                  bit_in   = scmp_pkg::FERMAT_TOP_BIT;
                  pacc_in  = 30'd1;
                  ret_in   = scmp_pkg::RET_INIT;
                  state_in = scmp_pkg::ST_PW_SQ;
               end else begin
                  k_in     = k_ff + KW'(1);
                  state_in = scmp_pkg::ST_FACT_MUL;
               end
            end
         end
         scmp_pkg::ST_PW_SQ: begin
            mm_start = 1'b1;
            state_in = scmp_pkg::ST_PW_SQW;
         end
         scmp_pkg::ST_PW_SQW: begin
            if (mm_done) begin
               pacc_in = mm_res;
               if (exp_ff[bit_ff]) begin
                  state_in = scmp_pkg::ST_PW_ML;
               end else begin
                  bit_in   = bit_next;
                  state_in = pw_next;
               end
            end
         end
         scmp_pkg::ST_PW_ML: begin
            mm_start = 1'b1;
            mm_b     = base_ff;
            state_in = scmp_pkg::ST_PW_MLW;
         end
         scmp_pkg::ST_PW_MLW: begin
            if (mm_done) begin
               pacc_in  = mm_res;
               bit_in   = bit_next;
               state_in = pw_next;
            end
         end
         scmp_pkg::ST_INV_INIT: begin
            i_we     = 1'b1;
            i_waddr  = KMAX;
            i_wdata  = pacc_ff;
            acc_in   = pacc_ff;
            k_in     = KMAX;
            state_in = scmp_pkg::ST_INV_MUL;
         end
         scmp_pkg::ST_INV_MUL: begin
            mm_start = 1'b1;
            mm_a     = acc_ff;
            mm_b     = 30'(k_ff);
            state_in = scmp_pkg::ST_INV_WAIT;
         end
         scmp_pkg::ST_INV_WAIT: begin
            if (mm_done) begin
               i_we    = 1'b1;
               i_waddr = k_ff - KW'(1);
               i_wdata = mm_res;
               acc_in  = mm_res;
               k_in    = k_ff - KW'(1);
               state_in = (k_ff == KW'(1)) ? scmp_pkg::ST_IDLE : scmp_pkg::ST_INV_MUL;
            end
         end
         scmp_pkg::ST_IDLE: begin
            if (start) begin
               exp_in  = LEN_MASK & 32'(req_sequence_length);
               m_in    = m_wide[KW-1:0];
               i_in    = '0;
               sum_in  = '0;
               f_raddr = m_wide[KW-1:0];
               if (m_wide == '0 || m_wide > MW'(MAX_KINDS)) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = '0;
               end else begin
                  state_in = scmp_pkg::ST_RDF;
               end
            end
         end
         scmp_pkg::ST_RDF: begin
            fm_in    = f_rdata;
            state_in = scmp_pkg::ST_TSTART;
         end
         scmp_pkg::ST_TSTART: begin
            base_in  = 30'(m_minus_i);
            pacc_in  = 30'd1;
            bit_in   = LEN_TOP;
            ret_in   = scmp_pkg::RET_TERM;
            state_in = scmp_pkg::ST_TRD;
         end
         scmp_pkg::ST_TRD: begin
            ifa_in   = i_rdata_a;
            ifb_in   = i_rdata_b;
            state_in = scmp_pkg::ST_PW_SQ;
         end
         scmp_pkg::ST_T1: begin
            mm_start = 1'b1;
            mm_b     = fm_ff;
            state_in = scmp_pkg::ST_T1W;
         end
         scmp_pkg::ST_T1W: begin
            if (mm_done) begin
               acc_in   = mm_res;
               state_in = scmp_pkg::ST_T2;
            end
         end
         scmp_pkg::ST_T2: begin
            mm_start = 1'b1;
            mm_a     = acc_ff;
            mm_b     = ifa_ff;
            state_in = scmp_pkg::ST_T2W;
         end
         scmp_pkg::ST_T2W: begin
            if (mm_done) begin
               acc_in   = mm_res;
               state_in = scmp_pkg::ST_T3;
            end
         end
         scmp_pkg::ST_T3: begin
            mm_start = 1'b1;
            mm_a     = acc_ff;
            mm_b     = ifb_ff;
            state_in = scmp_pkg::ST_T3W;
         end
         scmp_pkg::ST_T3W: begin
            if (mm_done) begin
               sum_in = new_sum;
               if (i_ff == m_ff - KW'(1)) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = new_sum;
                  state_in     = scmp_pkg::ST_IDLE;
               end else begin
                  i_in     = i_ff + KW'(1);
                  state_in = scmp_pkg::ST_TSTART;
               end
            end
         end
         default: begin
            state_in = scmp_pkg::ST_FACT_INIT;
         end
      endcase
   end

   assign busy      = (state_ff != scmp_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count < scmp_pkg::PRIME)) else $error("count not reduced");
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid)) else $error("transaction dropped");
`endif

endmodule

// ===== sv/scmp_modmul.sv =====
// Pipelined modular multiplier: 30x30 product reduced mod PRIME by Barrett.
`timescale 1ns / 1ps
module scmp_modmul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [29:0] op_a,
   input  logic [29:0] op_b,
   output logic        done,
   output logic [29:0] result
);

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [59:0] prod_ff;
   logic [61:0] qmu_ff;
   logic [31:0] xlo_ff;
   logic [31:0] r_ff;
   logic [29:0] res_ff;
   logic [30:0] q;
   logic [60:0] qp;
   logic [31:0] r_in;
   logic [29:0] res_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_comb begin
      q    = qmu_ff[61:31];
      qp   = 61'(q) * 61'(scmp_pkg::PRIME);
      r_in = xlo_ff - qp[31:0];
      // remainder is below 3*PRIME
      if (r_ff >= 32'(2 * 64'd1000000007)) begin
         res_in = 30'(r_ff - 32'(2 * 64'd1000000007));
      end else if (r_ff >= 32'(scmp_pkg::PRIME)) begin
         res_in = 30'(r_ff - 32'(scmp_pkg::PRIME));
      end else begin
         res_in = r_ff[29:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= 60'(op_a) * 60'(op_b);
      qmu_ff  <= 62'(prod_ff[59:29]) * 62'(scmp_pkg::BARRETT_MU);
      xlo_ff  <= prod_ff[31:0];
      r_ff    <= r_in;
      res_ff  <= res_in;
   end

   assign done   = v4_ff;
   assign result = res_ff;

endmodule

// ===== sv/scmp_tables.sv =====
// Factorial and inverse-factorial memories with registered reads.
`timescale 1ns / 1ps
module scmp_tables #(
   parameter int DEPTH = 1025,
   parameter int AW    = 11
) (
   input  logic          clock,
   input  logic          f_we,
   input  logic [AW-1:0] f_waddr,
   input  logic [29:0]   f_wdata,
   input  logic [AW-1:0] f_raddr,
   output logic [29:0]   f_rdata,
   input  logic          i_we,
   input  logic [AW-1:0] i_waddr,
   input  logic [29:0]   i_wdata,
   input  logic [AW-1:0] i_raddr_a,
   input  logic [AW-1:0] i_raddr_b,
   output logic [29:0]   i_rdata_a,
   output logic [29:0]   i_rdata_b
);

   logic [29:0] fact_mem [DEPTH];
   logic [29:0] ifact_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (f_we) begin
         fact_mem[f_waddr] <= f_wdata;
      end
      f_rdata <= fact_mem[f_raddr];
   end

   always_ff @(posedge clock) begin
      if (i_we) begin
         ifact_mem[i_waddr] <= i_wdata;
      end
      i_rdata_a <= ifact_mem[i_raddr_a];
      i_rdata_b <= ifact_mem[i_raddr_b];
   end

endmodule
